@@ hw/rtl/ircpd_pkg.sv @@
// Package for the infrared code pair decoder: opcodes, register indexes,
// sequencer states, field widths and the index width helper.
// No dependencies; imported by ir_code_pair_decoder.
package ircpd_pkg;

   // Default depth of the on/off timing table.
   localparam int TABLE_DEPTH_DEF = 16;

   // Field widths fixed by the interface.
   localparam int TIME_W      = 16;
   localparam int INDEX_W     = 4;
   localparam int BYTE_W      = 8;
   localparam int BPI_W       = 3;
   localparam int PCOUNT_W    = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   // Opcodes of an input beat.
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_CODE_BYTE   = 1'b1;

   // Register indexes (word address bits of the configuration port).
   localparam logic [1:0] REG_BITS_PER_INDEX = 2'd0;
   localparam logic [1:0] REG_PAIR_COUNT     = 2'd1;
   localparam logic [1:0] REG_CARRIER_PERIOD = 2'd2;

   // Slot index of the last pair one code byte can produce.
   localparam logic [2:0] LAST_SLOT = 3'd7;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXTRACT,
      ST_SEND
   } state_type;

   // Effective index width: zero acts as one, five and up act as four.
   function automatic logic [2:0] index_width(input logic [2:0] bpi);
      logic [2:0] w;
      if (bpi == 3'd0) begin
         w = 3'd1;
      end else if (bpi > 3'd4) begin
         w = 3'd4;
      end else begin
         w = bpi;
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/ir_code_pair_decoder.sv @@
// Top level of the infrared code pair decoder: timing table memory, index
// extraction sequencer, result register and configuration registers.
// Depends on ircpd_pkg.

// The block takes two kinds of input beats. A table write (opcode 0) stores
// one on/off pair in the timing table. A code byte (opcode 1) is unpacked
// most significant bit first into table indices of bits_per_index bits;
// each index gives one result beat with its table pair. Bits that do not
// fill a whole index are kept for the next byte, and they are dropped when
// a code ends after pair_count pairs. A code byte gives n result beats (n
// is 1 to 8): each pair is extracted on the shared shifter and read from
// the table read port, then presented from the result register until the
// receiver takes it. No new beat is accepted until the last pair of the
// current byte has been delivered. Writing bits_per_index or pair_count
// drops kept bits and restarts the pair count.
module ir_code_pair_decoder
   import ircpd_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [INDEX_W-1:0]    req_table_index,
   input  logic [TIME_W-1:0]     req_on_value,
   input  logic [TIME_W-1:0]     req_off_value,
   input  logic [BYTE_W-1:0]     req_code_byte,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TIME_W-1:0]     rsp_on_time,
   output logic [TIME_W-1:0]     rsp_off_time,
   output logic                  rsp_carrier_on,
   output logic                  rsp_last_of_item,
   output logic                  rsp_code_done,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

   // Sequencer and configuration state.
   state_type             state_ff, state_in;
   logic [BPI_W-1:0]      bpi_ff;
   logic [PCOUNT_W-1:0]   pcount_ff;
   logic [TIME_W-1:0]     carrier_ff;
   logic [2:0]            lbits_ff, lbits_in;
   logic [1:0]            lcount_ff, lcount_in;
   logic [PCOUNT_W-1:0]   sent_ff, sent_in;

   // Working registers of the current code byte.
   logic [10:0]           acc_ff, acc_in;
   logic [3:0]            avail_ff, avail_in;
   logic [2:0]            slot_ff, slot_in;

   // Result flags and table read data.
   logic                  hit_ff, hit_in;
   logic                  car_ff, car_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;
   logic [TIME_W-1:0]     on_rd_ff;
   logic [TIME_W-1:0]     off_rd_ff;

   // Timing table memories.
   logic [TIME_W-1:0]     on_mem  [TABLE_DEPTH];
   logic [TIME_W-1:0]     off_mem [TABLE_DEPTH];

   logic                  req_beat;
   logic                  rsp_beat;
   logic                  cfg_we;
   logic [1:0]            cfg_idx;
   logic                  tbl_we;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [2:0]            width;
   logic [3:0]            mask;
   logic [3:0]            new_avail;
   logic [3:0]            idx;
   logic                  pair_done;
   logic                  keep_stale;
   logic [1:0]            lc_eff;
   logic [2:0]            lb_eff;

   // Handshakes.
   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign cfg_we   = psel && penable && pwrite && pready;
   assign cfg_idx  = paddr[3:2];
   assign pready   = 1'b1;

   // Shared shifter: pull the next index out of the accumulator.
   assign width     = index_width(bpi_ff);
   assign mask      = 4'((5'd1 << width) - 5'd1);
   assign new_avail = avail_ff - {1'b0, width};
   assign idx       = 4'(acc_ff >> new_avail) & mask;
   assign pair_done = (sent_ff + 8'd1) == pcount_ff;
   assign rd_addr   = ADDR_W'(idx);
   assign rd_en     = (state_ff == ST_EXTRACT);

   // Kept bits are discarded when they already cover a whole index.
   assign keep_stale = {1'b0, lcount_ff} >= width;
   assign lc_eff     = keep_stale ? 2'd0 : lcount_ff;
   assign lb_eff     = keep_stale ? 3'd0 : lbits_ff;

   assign tbl_we = req_beat && (req_opcode == OP_TABLE_WRITE)
                   && ({5'd0, req_table_index} < DEPTH_LIM);

   // Next state, handshake outputs and next values of the working registers.
   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      avail_in  = avail_ff;
      slot_in   = slot_ff;
      lbits_in  = lbits_ff;
      lcount_in = lcount_ff;
      sent_in   = sent_ff;
      hit_in    = hit_ff;
      car_in    = car_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_SEND);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_opcode == OP_CODE_BYTE)) begin
               acc_in   = {lb_eff, req_code_byte};
               avail_in = {2'd0, lc_eff} + 4'd8;
               slot_in  = 3'd0;
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            hit_in  = ({5'd0, idx} < DEPTH_LIM);
            car_in  = (carrier_ff != '0);
            done_in = pair_done;
            last_in = pair_done || (new_avail < {1'b0, width}) || (slot_ff == LAST_SLOT);
            if (pair_done) begin
               sent_in  = '0;
               avail_in = 4'd0;
            end else begin
               sent_in  = sent_ff + 8'd1;
               avail_in = new_avail;
            end
            // Bits left at the end of the byte are kept for the next one.
            if (last_in) begin
               lcount_in = pair_done ? 2'd0 : new_avail[1:0];
               lbits_in  = acc_ff[2:0] & 3'((4'd1 << lcount_in) - 4'd1);
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_beat) begin
               slot_in  = slot_ff + 3'd1;
               state_in = last_ff ? ST_IDLE : ST_EXTRACT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A width or count write restarts the code.
      if (cfg_we && ((cfg_idx == REG_BITS_PER_INDEX) || (cfg_idx == REG_PAIR_COUNT))) begin
         lbits_in  = 3'd0;
         lcount_in = 2'd0;
         sent_in   = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lbits_ff  <= 3'd0;
         lcount_ff <= 2'd0;
         sent_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         lbits_ff  <= lbits_in;
         lcount_ff <= lcount_in;
         sent_ff   <= sent_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpi_ff     <= 3'd2;
         pcount_ff  <= 8'd1;
         carrier_ff <= '0;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_BITS_PER_INDEX: bpi_ff     <= pwdata[BPI_W-1:0];
            REG_PAIR_COUNT:     pcount_ff  <= pwdata[PCOUNT_W-1:0];
            REG_CARRIER_PERIOD: carrier_ff <= pwdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (cfg_idx)
         REG_BITS_PER_INDEX: prdata = {29'd0, bpi_ff};
         REG_PAIR_COUNT:     prdata = {24'd0, pcount_ff};
         REG_CARRIER_PERIOD: prdata = {16'd0, carrier_ff};
         default:            prdata = '0;
      endcase
   end

   // Working and result registers; payload only, no reset needed.
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      avail_ff <= avail_in;
      slot_ff  <= slot_in;
      hit_ff   <= hit_in;
      car_ff   <= car_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   // Timing table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         on_mem[ADDR_W'(req_table_index)]  <= req_on_value;
         off_mem[ADDR_W'(req_table_index)] <= req_off_value;
      end
      if (rd_en) begin
         on_rd_ff  <= on_mem[rd_addr];
         off_rd_ff <= off_mem[rd_addr];
      end
   end

   // Result beat fields; indices past the table read as zero.
   assign rsp_on_time      = hit_ff ? on_rd_ff : '0;
   assign rsp_off_time     = hit_ff ? off_rd_ff : '0;
   assign rsp_carrier_on   = car_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_code_done    = done_ff;

`ifndef SYNTHESIS
   // A code byte keeps the input side stalled on the next cycle.
   a_byte_stalls: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_opcode == OP_CODE_BYTE) |=> req_stall)
      else $error("input not stalled after a code byte");

   // The end of a code is always the last pair of its byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_done |-> rsp_last_of_item)
      else $error("code_done without last_of_item");

   // After the last pair of a byte is taken the block is ready again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_last_of_item |=> !req_stall && !rsp_valid)
      else $error("block not idle after last pair");

   // The accumulator never holds more than eleven unused bits.
   a_avail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXTRACT) |-> (avail_ff <= 4'd11) && (avail_ff >= {1'b0, width}))
      else $error("bit count out of range during extraction");
`endif

endmodule

@@ dv/tb_top.sv @@
// Testbench for ir_code_pair_decoder: random and directed beats against a
// self-checking pulse pair predictor held in a small scoreboard class.
// Depends on ircpd_pkg and the ir_code_pair_decoder RTL.
`timescale 1ns / 100ps

module tb_top;
   import ircpd_pkg::*;

   // Unused register index: a write there must change nothing.
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int NUM_PHASES = 8;
   localparam int TABLE_ENTRIES = 16;

   // One input beat and one result beat.
   typedef struct packed {
      logic                opcode;
      logic [INDEX_W-1:0]  table_index;
      logic [TIME_W-1:0]   on_value;
      logic [TIME_W-1:0]   off_value;
      logic [BYTE_W-1:0]   code_byte;
   } ir_beat_type;

   typedef struct packed {
      logic [TIME_W-1:0]   on_time;
      logic [TIME_W-1:0]   off_time;
      logic                carrier_on;
      logic                last_of_item;
      logic                code_done;
   } pulse_pair_type;

   // Predicts the pulse pairs of each accepted beat and checks them in order.
   class pulse_pair_scoreboard;
      logic [BPI_W-1:0]    bits_per_index;
      logic [PCOUNT_W-1:0] pair_count;
      logic [TIME_W-1:0]   carrier_period;
      logic [TIME_W-1:0]   on_table [TABLE_ENTRIES];
      logic [TIME_W-1:0]   off_table [TABLE_ENTRIES];
      logic [2:0]          kept_bits;
      logic [1:0]          kept_count;
      logic [7:0]          pairs_in_code;
      pulse_pair_type      pending_pairs[$];
      int                  errors;

      function new();
         bits_per_index = 3'd2;
         pair_count     = 8'd1;
         carrier_period = '0;
         kept_bits      = '0;
         kept_count     = '0;
         pairs_in_code  = '0;
         errors         = 0;
      endfunction

      // Register write; index width and pair count restart the code.
      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_BITS_PER_INDEX: begin
               bits_per_index = value[BPI_W-1:0];
               kept_bits = '0;
               kept_count = '0;
               pairs_in_code = '0;
            end
            REG_PAIR_COUNT: begin
               pair_count = value[PCOUNT_W-1:0];
               kept_bits = '0;
               kept_count = '0;
               pairs_in_code = '0;
            end
            REG_CARRIER_PERIOD: carrier_period = value[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      // Note an accepted input beat and queue the pairs it must produce.
      function void note_beat(ir_beat_type b);
         int unsigned width;
         int unsigned avail;
         int unsigned n;
         logic [10:0] acc;
         logic [3:0]  idx;
         logic [7:0]  next_count;
         pulse_pair_type p;
         pulse_pair_type burst[$];
         if (b.opcode == OP_TABLE_WRITE) begin
            on_table[b.table_index] = b.on_value;
            off_table[b.table_index] = b.off_value;
            return;
         end
         // Out-of-range widths clamp to the nearest legal one.
         case (bits_per_index)
            3'd0, 3'd1: width = 1;
            3'd2: width = 2;
            3'd3: width = 3;
            default: width = 4;
         endcase
         if (kept_count >= width) begin
            kept_count = '0;
            kept_bits = '0;
         end
         acc = {kept_bits, b.code_byte};
         avail = kept_count + 8;
         n = 0;
         // Pull indices off the top of the accumulated bits.
         while (avail >= width && n < 8) begin
            avail = avail - width;
            idx = 4'((acc >> avail) & ((1 << width) - 1));
            next_count = pairs_in_code + 8'd1;
            p.on_time = on_table[idx];
            p.off_time = off_table[idx];
            p.carrier_on = (carrier_period != '0);
            p.last_of_item = 1'b0;
            p.code_done = (next_count == pair_count);
            n++;
            // The end of a code drops whatever bits are left.
            if (p.code_done) begin
               pairs_in_code = '0;
               avail = 0;
            end else begin
               pairs_in_code = next_count;
            end
            burst.push_back(p);
         end
         burst[burst.size() - 1].last_of_item = 1'b1;
         foreach (burst[i]) pending_pairs.push_back(burst[i]);
         kept_count = avail[1:0];
         kept_bits = 3'(acc & ((1 << kept_count) - 1));
      endfunction

      function void report(string field, logic [15:0] want, logic [15:0] got);
         errors++;
         $display("%0t: %s expected %h got %h", $time, field, want, got);
      endfunction

      // Compare one delivered pair with the oldest expected one.
      function void check_pair(pulse_pair_type got);
         pulse_pair_type want;
         if (pending_pairs.size() == 0) begin
            errors++;
            $display("%0t: pair with nothing expected, on %h off %h", $time,
                     got.on_time, got.off_time);
            return;
         end
         want = pending_pairs.pop_front();
         if (got.on_time !== want.on_time)
            report("on_time", want.on_time, got.on_time);
         if (got.off_time !== want.off_time)
            report("off_time", want.off_time, got.off_time);
         if (got.carrier_on !== want.carrier_on)
            report("carrier_on", 16'(want.carrier_on), 16'(got.carrier_on));
         if (got.last_of_item !== want.last_of_item)
            report("last_of_item", 16'(want.last_of_item), 16'(got.last_of_item));
         if (got.code_done !== want.code_done)
            report("code_done", 16'(want.code_done), 16'(got.code_done));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_opcode;
   logic [INDEX_W-1:0]    req_table_index;
   logic [TIME_W-1:0]     req_on_value;
   logic [TIME_W-1:0]     req_off_value;
   logic [BYTE_W-1:0]     req_code_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [TIME_W-1:0]     rsp_on_time;
   logic [TIME_W-1:0]     rsp_off_time;
   logic                  rsp_carrier_on;
   logic                  rsp_last_of_item;
   logic                  rsp_code_done;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pulse_pair_scoreboard sb = new();
   pulse_pair_type observed_pair;
   bit hold_off_go = 1'b0;
   bit hold_off_done = 1'b0;

   // Settings per phase; the last phase picks its own at random.
   logic [2:0]  phase_bpi [NUM_PHASES] = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2, 3'd2};
   logic [7:0]  phase_pc [NUM_PHASES] = '{8'd255, 8'd1, 8'd7, 8'd0, 8'd3, 8'd12, 8'd4, 8'd1};
   logic [15:0] phase_carrier [NUM_PHASES] =
      '{16'hFFFF, 16'h0000, 16'd1234, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000};
   int          phase_beats [NUM_PHASES] = '{24, 24, 28, 45, 24, 28, 28, 28};
   int          phase_gap [NUM_PHASES] = '{0, 6, 3, 4, 10, 2, 5, 8};

   ir_code_pair_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_table_index  (req_table_index),
      .req_on_value     (req_on_value),
      .req_off_value    (req_off_value),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_on_time      (rsp_on_time),
      .rsp_off_time     (rsp_off_time),
      .rsp_carrier_on   (rsp_carrier_on),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_code_done    (rsp_code_done),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one beat and hold it until the block takes it.
   task automatic send_beat(ir_beat_type b);
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= b.opcode;
      req_table_index <= b.table_index;
      req_on_value <= b.on_value;
      req_off_value <= b.off_value;
      req_code_byte <= b.code_byte;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_beat(b);
   endtask

   task automatic idle_cycles(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Wait for every expected pair, then give a trailing table write time to land.
   task automatic wait_drained();
      while (sb.pending_pairs.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Register write, then read back where the register exists.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      logic [31:0] want;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_reg(idx, value);
      if (idx != REG_UNUSED) begin
         @(negedge clock);
         penable <= 1'b0;
         pwrite <= 1'b0;
         @(negedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (pready !== 1'b1);
         case (idx)
            REG_BITS_PER_INDEX: want = 32'(sb.bits_per_index);
            REG_PAIR_COUNT:     want = 32'(sb.pair_count);
            default:            want = 32'(sb.carrier_period);
         endcase
         if (prdata !== want) begin
            sb.errors++;
            $display("%0t: register %0d read expected %h got %h", $time, idx, want,
                     prdata);
         end
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Random beats in bursts separated by random gaps.
   task automatic run_phase(int count, int gap_max, bit pause_midway);
      int sent;
      int burst;
      int gap;
      ir_beat_type b;
      sent = 0;
      while (sent < count) begin
         burst = int'($urandom_range(1, 12));
         while (burst > 0 && sent < count) begin
            b.opcode = ($urandom_range(0, 99) < 18) ? OP_TABLE_WRITE : OP_CODE_BYTE;
            b.table_index = INDEX_W'($urandom);
            case ($urandom_range(0, 3))
               0: b.on_value = '0;
               1: b.on_value = '1;
               default: b.on_value = TIME_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: b.off_value = '0;
               1: b.off_value = '1;
               default: b.off_value = TIME_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0: b.code_byte = 8'h00;
               1: b.code_byte = 8'hFF;
               default: b.code_byte = BYTE_W'($urandom);
            endcase
            send_beat(b);
            sent++;
            burst--;
            // Sender pause: let the block empty completely before going on.
            if (pause_midway && sent == count / 2) begin
               idle_cycles(1);
               wait_drained();
            end
         end
         gap = int'($urandom_range(0, gap_max));
         if (gap > 0) idle_cycles(gap);
      end
   endtask

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      int stretch;
      int mode;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end
         stretch = int'($urandom_range(1, 24));
         mode = int'($urandom_range(0, 3));
         repeat (stretch) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Result monitor: check each accepted result beat.
   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            observed_pair.on_time = rsp_on_time;
            observed_pair.off_time = rsp_off_time;
            observed_pair.carrier_on = rsp_carrier_on;
            observed_pair.last_of_item = rsp_last_of_item;
            observed_pair.code_done = rsp_code_done;
            sb.check_pair(observed_pair);
         end
      end
   end

   // Main sequence.
   initial begin
      ir_beat_type b;
      logic [2:0]  bpi;
      logic [7:0]  pc;
      logic [15:0] carrier;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TABLE_WRITE;
      req_table_index = '0;
      req_on_value = '0;
      req_off_value = '0;
      req_code_byte = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole timing table first, with extreme values at both ends.
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         b.opcode = OP_TABLE_WRITE;
         b.table_index = INDEX_W'(i);
         b.on_value = (i == 0) ? 16'h0000 :
                      (i == TABLE_ENTRIES - 1) ? 16'hFFFF : TIME_W'($urandom);
         b.off_value = (i == 0) ? 16'hFFFF :
                       (i == TABLE_ENTRIES - 1) ? 16'h0000 : TIME_W'($urandom);
         b.code_byte = BYTE_W'($urandom);
         send_beat(b);
      end
      // Code bytes at reset settings: every pair ends a code and drops the rest.
      b.opcode = OP_CODE_BYTE;
      b.code_byte = 8'h00;
      send_beat(b);
      b.code_byte = 8'hFF;
      send_beat(b);
      b.code_byte = 8'hA5;
      send_beat(b);
      b.code_byte = 8'h5A;
      send_beat(b);
      b.code_byte = 8'h3C;
      send_beat(b);
      idle_cycles(1);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         bpi = phase_bpi[ph];
         pc = phase_pc[ph];
         carrier = phase_carrier[ph];
         if (ph == NUM_PHASES - 1) begin
            bpi = 3'($urandom_range(0, 7));
            pc = 8'($urandom_range(0, 255));
            carrier = 16'($urandom);
         end
         csr_write(REG_BITS_PER_INDEX, 32'(bpi));
         csr_write(REG_PAIR_COUNT, 32'(pc));
         csr_write(REG_CARRIER_PERIOD, 32'(carrier));
         if (ph == 3) csr_write(REG_UNUSED, 32'hFFFF_FFFF);
         // Long receiver hold-off while beats keep coming.
         if (ph == 2) hold_off_go = 1'b1;
         run_phase(phase_beats[ph], phase_gap[ph], ph == 5);
         idle_cycles(1);
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending_pairs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/ircpd_pkg.sv
hw/rtl/ir_code_pair_decoder.sv
dv/tb_top.sv
